// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
// No dependencies; assertions are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/pip_pkg.sv -----
// Package for the point-in-polygon classifier: widths, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int COORD_BITS    = 32;   // working coordinate width (8..32)
   localparam int FIELD_BITS    = 32;   // width of coordinate fields and registers
   localparam int DIV_CNT_BITS  = $clog2(COORD_BITS);
   localparam int CLASS_BITS    = 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_QUERY_X = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUERY_Y = 1'd1;

   localparam logic [CLASS_BITS-1:0] CLASS_OUTSIDE  = 2'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_INSIDE   = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_BOUNDARY = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // edge check request: endpoints a and b plus the query point
   typedef struct packed {
      logic      start;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
      coord_type qx;
      coord_type qy;
   } edge_cmd_type;

   // edge check status and outcome
   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
      logic toggle;
   } edge_res_type;

endpackage

// ----- rtl/pip_if.sv -----
// Valid/ready channel interfaces for vertex requests and classification results.
// Depends on pip_pkg.
`timescale 1ns / 1ps

interface pip_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pip_pkg::FIELD_BITS-1:0]  vertex_x;
   logic signed [pip_pkg::FIELD_BITS-1:0]  vertex_y;
   logic                                   final_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output final_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input final_vertex,
                   output ready);
endinterface

interface pip_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [pip_pkg::CLASS_BITS-1:0]    classification;

   modport source (output valid, output classification, input ready);
   modport sink   (input valid, input classification, output ready);
endinterface

// ----- rtl/pip_divider.sv -----
// Restoring divider, one quotient bit per cycle, a COORD_BITS-bit quotient per divide.
// Needs num_hi < den so the quotient fits COORD_BITS bits. Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pip_pkg::COORD_BITS-1:0]   num_hi,
   input  logic [pip_pkg::COORD_BITS-1:0]   num_lo,
   input  logic [pip_pkg::COORD_BITS-1:0]   den,
   output logic                             done,
   output logic [pip_pkg::COORD_BITS-1:0]   quot
);

   localparam int W = pip_pkg::COORD_BITS;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [pip_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                       rem_ff, rem_in;
   logic [W-1:0]                       lo_ff, lo_in;
   logic [W-1:0]                       den_ff, den_in;
   logic [W-1:0]                       quot_ff, quot_in;

   logic [W:0] trial;
   logic [W:0] diff;
   logic       ge;

   always_comb begin
      trial = {rem_ff, lo_ff[W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = pip_pkg::DIV_CNT_BITS'(W - 1);
         rem_in  = num_hi;
         lo_in   = num_lo;
         den_in  = den;
      end else if (busy_ff) begin
         // remainder stays below den, so W bits hold it
         rem_in  = ge ? diff[W-1:0] : trial[W-1:0];
         lo_in   = {lo_ff[W-2:0], 1'b0};
         quot_in = {quot_ff[W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- rtl/pip_csr.sv -----
// APB-style register file holding the query point.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pip_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pip_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pip_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output logic [pip_pkg::FIELD_BITS-1:0]      query_x,
   output logic [pip_pkg::FIELD_BITS-1:0]      query_y
);

   logic [pip_pkg::FIELD_BITS-1:0]   query_x_ff, query_x_in;
   logic [pip_pkg::FIELD_BITS-1:0]   query_y_ff, query_y_in;
   logic [pip_pkg::CSR_IDX_BITS-1:0] idx;
   logic                             wr_en;

   assign idx        = csr_paddr[pip_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      query_x_in = query_x_ff;
      query_y_in = query_y_ff;
      if (wr_en) begin
         case (idx)
            pip_pkg::REG_QUERY_X: query_x_in = csr_pwdata;
            pip_pkg::REG_QUERY_Y: query_y_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         pip_pkg::REG_QUERY_X: csr_prdata = query_x_ff;
         pip_pkg::REG_QUERY_Y: csr_prdata = query_y_ff;
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else begin
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
      end
   end

   assign query_x = query_x_ff;
   assign query_y = query_y_ff;

endmodule

// ----- rtl/pip_edge.sv -----
// Edge checker: orders one edge, tests it against the query point and, when the
// scanline crossing must be located, runs a multiply and its own divider.
// Depends on pip_pkg and pip_divider.
`timescale 1ns / 1ps

module pip_edge (
   input  logic                  clock,
   input  logic                  reset,
   input  pip_pkg::edge_cmd_type cmd,
   output pip_pkg::edge_res_type res
);

   localparam int W = pip_pkg::COORD_BITS;

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_ORDER = 3'd1;
   localparam logic [2:0] E_CLASS = 3'd2;
   localparam logic [2:0] E_MUL   = 3'd3;
   localparam logic [2:0] E_DGO   = 3'd4;
   localparam logic [2:0] E_DWAIT = 3'd5;
   localparam logic [2:0] E_XI    = 3'd6;

   logic [2:0] state_ff, state_in;

   pip_pkg::coord_type ax_ff, ay_ff, bx_ff, by_ff, qx_ff, qy_ff;
   pip_pkg::coord_type x1_ff, y1_ff, x2_ff, y2_ff;
   pip_pkg::coord_type x1_in, y1_in, x2_in, y2_in;
   logic               neg_ff, neg_in;
   logic [W-1:0]       mag_ff, mag_in;
   logic [W-1:0]       t_ff, t_in;
   logic [W-1:0]       dy_ff, dy_in;
   logic [2*W-1:0]     prod_ff, prod_in;
   logic               done_ff, done_in;
   logic               hit_ff, hit_in;
   logic               toggle_ff, toggle_in;

   logic               swap;
   logic               on_vert, on_horz, on_low, span, l1, l2;
   logic signed [W:0]  x1w, x2w, y1w, y2w, qyw;
   logic signed [W:0]  dx_pos, dx_neg, t_full, dy_full;
   logic signed [W+1:0] x1e, qxe, qe, xi;

   logic               div_start;
   logic               div_done;
   logic [W-1:0]       div_quot;

   pip_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num_hi (prod_ff[2*W-1:W]),
      .num_lo (prod_ff[W-1:0]),
      .den    (dy_ff),
      .done   (div_done),
      .quot   (div_quot)
   );

   assign div_start = (state_ff == E_DGO);

   always_comb begin
      // lower endpoint first: by y, then by x
      swap  = (ay_ff > by_ff) || ((ay_ff == by_ff) && (ax_ff > bx_ff));
      x1_in = swap ? bx_ff : ax_ff;
      y1_in = swap ? by_ff : ay_ff;
      x2_in = swap ? ax_ff : bx_ff;
      y2_in = swap ? ay_ff : by_ff;

      on_vert = (x1_ff == x2_ff) && (qx_ff == x1_ff) && (qy_ff >= y1_ff) && (qy_ff <= y2_ff);
      on_horz = (y1_ff == y2_ff) && (qy_ff == y1_ff) && (qx_ff >= x1_ff) && (qx_ff <= x2_ff);
      on_low  = (qx_ff == x1_ff) && (qy_ff == y1_ff);
      span    = (y1_ff <= qy_ff) && (y2_ff > qy_ff);
      l1      = (x1_ff < qx_ff);
      l2      = (x2_ff < qx_ff);

      x1w     = {x1_ff[W-1], x1_ff};
      x2w     = {x2_ff[W-1], x2_ff};
      y1w     = {y1_ff[W-1], y1_ff};
      y2w     = {y2_ff[W-1], y2_ff};
      qyw     = {qy_ff[W-1], qy_ff};
      dx_pos  = x2w - x1w;
      dx_neg  = x1w - x2w;
      t_full  = qyw - y1w;
      dy_full = y2w - y1w;
      neg_in  = (x2_ff < x1_ff);
      mag_in  = neg_in ? dx_neg[W-1:0] : dx_pos[W-1:0];
      t_in    = t_full[W-1:0];
      dy_in   = dy_full[W-1:0];

      prod_in = mag_ff * t_ff;

      x1e = {{2{x1_ff[W-1]}}, x1_ff};
      qxe = {{2{qx_ff[W-1]}}, qx_ff};
      qe  = {2'b00, div_quot};
      xi  = neg_ff ? (x1e - qe) : (x1e + qe);
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      hit_in    = 1'b0;
      toggle_in = 1'b0;
      case (state_ff)
         E_IDLE: begin
            if (cmd.start) state_in = E_ORDER;
         end
         E_ORDER: state_in = E_CLASS;
         E_CLASS: begin
            if (on_vert || on_horz || on_low) begin
               done_in  = 1'b1;
               hit_in   = 1'b1;
               state_in = E_IDLE;
            end else if (span && l1 && l2) begin
               done_in   = 1'b1;
               toggle_in = 1'b1;
               state_in  = E_IDLE;
            end else if (span && (l1 || l2)) begin
               state_in = E_MUL;
            end else begin
               done_in  = 1'b1;
               state_in = E_IDLE;
            end
         end
         E_MUL:   state_in = E_DGO;
         E_DGO:   state_in = E_DWAIT;
         E_DWAIT: begin
            if (div_done) state_in = E_XI;
         end
         E_XI: begin
            done_in   = 1'b1;
            hit_in    = (xi == qxe);
            toggle_in = (xi < qxe);
            state_in  = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      hit_ff    <= hit_in;
      toggle_ff <= toggle_in;
      if (cmd.start && (state_ff == E_IDLE)) begin
         ax_ff <= cmd.ax;
         ay_ff <= cmd.ay;
         bx_ff <= cmd.bx;
         by_ff <= cmd.by;
         qx_ff <= cmd.qx;
         qy_ff <= cmd.qy;
      end
      if (state_ff == E_ORDER) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         x2_ff <= x2_in;
         y2_ff <= y2_in;
      end
      if (state_ff == E_CLASS) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         t_ff   <= t_in;
         dy_ff  <= dy_in;
      end
      if (state_ff == E_MUL) prod_ff <= prod_in;
   end

   assign res.busy   = (state_ff != E_IDLE);
   assign res.done   = done_ff;
   assign res.hit    = hit_ff;
   assign res.toggle = toggle_ff;

endmodule

// ----- rtl/point_in_polygon_classify.sv -----
// Point-in-polygon classifier, top level.
// Depends on pip_pkg, pip_if, pip_csr, pip_edge, pip_divider, assert_macros.svh.
//
// Usage: write query_x (0x0) and query_y (0x4) over the csr_ APB port while idle,
// then stream the polygon's vertices on req_ch, one transaction per vertex, with
// final_vertex set on the last one. Only that last vertex yields a transaction on
// rsp_ch: classification 0 outside, 1 inside, 2 on the boundary. A polygon of a
// single vertex gives outside.
// Each vertex after the first forms an edge with the previous one; the final
// vertex also closes the polygon back to the first. An edge settled by compares
// alone is ordered, then classified; one whose scanline crossing must be located
// then also runs a multiply, a divide on the one-bit-per-cycle divider that the
// edge checker reuses, and a compare of the crossing. Once a boundary hit is found
// the remaining edges are skipped. req_ch.ready is high only between vertices;
// a result may sit unclaimed on rsp_ch while the next polygon starts, and a
// further result waits until the held one is taken.
// Synchronous active-high reset clears the query registers, the vertex count,
// parity and boundary flags, and drops rsp_ch.valid. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_in_polygon_classify (
   input  logic                                clock,
   input  logic                                reset,
   pip_req_if.sink                             req_ch,
   pip_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pip_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pip_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pip_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int W = pip_pkg::COORD_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [pip_pkg::FIELD_BITS-1:0] query_x, query_y;

   logic [1:0]          state_ff, state_in;
   pip_pkg::coord_type  first_x_ff, first_x_in, first_y_ff, first_y_in;
   pip_pkg::coord_type  prior_x_ff, prior_x_in, prior_y_ff, prior_y_in;
   pip_pkg::coord_type  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                fin_ff, fin_in;
   logic                closing_ff, closing_in;
   logic [1:0]          seen_ff, seen_in;
   logic                parity_ff, parity_in;
   logic                boundary_ff, boundary_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [pip_pkg::CLASS_BITS-1:0] class_ff, class_in;

   pip_pkg::coord_type    vx, vy;
   logic                  accept;
   logic                  edge_fin;
   logic                  rsp_load;
   pip_pkg::edge_cmd_type edge_cmd;
   pip_pkg::edge_res_type edge_res;

   pip_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .query_x     (query_x),
      .query_y     (query_y)
   );

   pip_edge u_edge (
      .clock (clock),
      .reset (reset),
      .cmd   (edge_cmd),
      .res   (edge_res)
   );

   assign vx     = req_ch.vertex_x[W-1:0];
   assign vy     = req_ch.vertex_y[W-1:0];
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept = req_ch.valid && (state_ff == S_IDLE);

   // closing edge runs from the last vertex back to the first
   assign edge_cmd.start = (state_ff == S_START) && !boundary_ff;
   assign edge_cmd.ax    = closing_ff ? cur_x_ff   : prior_x_ff;
   assign edge_cmd.ay    = closing_ff ? cur_y_ff   : prior_y_ff;
   assign edge_cmd.bx    = closing_ff ? first_x_ff : cur_x_ff;
   assign edge_cmd.by    = closing_ff ? first_y_ff : cur_y_ff;
   assign edge_cmd.qx    = query_x[W-1:0];
   assign edge_cmd.qy    = query_y[W-1:0];

   assign edge_fin = ((state_ff == S_START) && boundary_ff) ||
                     ((state_ff == S_WAIT) && edge_res.done);
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prior_x_in   = prior_x_ff;
      prior_y_in   = prior_y_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      fin_in       = fin_ff;
      closing_in   = closing_ff;
      seen_in      = seen_ff;
      parity_in    = parity_ff;
      boundary_in  = boundary_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      class_in     = class_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fin_in = req_ch.final_vertex;
               if (seen_ff == 2'd0) begin
                  first_x_in = vx;
                  first_y_in = vy;
                  prior_x_in = vx;
                  prior_y_in = vy;
                  seen_in    = 2'd1;
                  if (req_ch.final_vertex) state_in = S_OUT;
               end else begin
                  cur_x_in   = vx;
                  cur_y_in   = vy;
                  closing_in = 1'b0;
                  state_in   = S_START;
               end
            end
         end
         S_START: begin
            if (!boundary_ff) state_in = S_WAIT;
         end
         S_WAIT: ;
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               if (boundary_ff)    class_in = pip_pkg::CLASS_BOUNDARY;
               else if (parity_ff) class_in = pip_pkg::CLASS_INSIDE;
               else                class_in = pip_pkg::CLASS_OUTSIDE;
               seen_in     = 2'd0;
               parity_in   = 1'b0;
               boundary_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (edge_fin) begin
         if (state_ff == S_WAIT) begin
            parity_in   = parity_ff ^ (edge_res.toggle && !edge_res.hit);
            boundary_in = boundary_ff | edge_res.hit;
         end
         if (closing_ff) begin
            state_in = S_OUT;
         end else begin
            prior_x_in = cur_x_ff;
            prior_y_in = cur_y_ff;
            seen_in    = 2'd2;
            if (fin_ff) begin
               closing_in = 1'b1;
               state_in   = S_START;
            end else begin
               state_in = S_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prior_x_ff   <= '0;
         prior_y_ff   <= '0;
         seen_ff      <= 2'd0;
         parity_ff    <= 1'b0;
         boundary_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         closing_ff   <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prior_x_ff   <= prior_x_in;
         prior_y_ff   <= prior_y_in;
         seen_ff      <= seen_in;
         parity_ff    <= parity_in;
         boundary_ff  <= boundary_in;
         rsp_valid_ff <= rsp_valid_in;
         closing_ff   <= closing_in;
         fin_ff       <= fin_in;
      end
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      class_ff <= class_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.classification = class_ff;

   `ASSERT_IMPLIES(a_class_legal, clock, reset, rsp_valid_ff, (class_ff == pip_pkg::CLASS_OUTSIDE) || (class_ff == pip_pkg::CLASS_INSIDE) || (class_ff == pip_pkg::CLASS_BOUNDARY))
   `ASSERT_IMPLIES(a_edge_start_idle, clock, reset, edge_cmd.start, !edge_res.busy)
   `ASSERT_NEXT(a_clear_after_result, clock, reset, rsp_load, !parity_ff && !boundary_ff && (seen_ff == 2'd0))
   `ASSERT_IMPLIES(a_parity_frozen, clock, reset, boundary_ff && $past(boundary_ff), $stable(parity_ff))

endmodule

// ----- dv/point_in_polygon_classify_tb.sv -----
// Testbench for point_in_polygon_classify: streams polygons and checks each classification.
// Uses pip_pkg and the pip_req_if / pip_rsp_if channel interfaces; predicts with its own model.
// Query registers are set over the csr_ port between phases of directed and random polygons.
`timescale 1ns / 1ps

module point_in_polygon_classify_tb;
   import pip_pkg::*;

   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int SETTLE_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT   = 8000;
   localparam int PHASE_ITEMS      = 220;

   typedef struct packed {
      logic [FIELD_BITS-1:0] x;
      logic [FIELD_BITS-1:0] y;
      logic                  last;
   } vertex_item_type;

   logic clock = 1'b0;
   logic reset;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pip_req_if req_ch();
   pip_rsp_if rsp_ch();

   point_in_polygon_classify dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // stimulus and expected classifications
   vertex_item_type       vertex_pending_q[$];
   logic [CLASS_BITS-1:0] class_expected_q[$];
   int vertices_queued   = 0;
   int vertices_accepted = 0;
   int mismatch_count    = 0;

   // predictor state
   logic [FIELD_BITS-1:0] query_x_cfg = '0;
   logic [FIELD_BITS-1:0] query_y_cfg = '0;
   longint first_x, first_y, prev_x, prev_y;
   int     corners_seen = 0;
   logic   crossing_odd = 1'b0;
   logic   on_boundary  = 1'b0;

   // pacing
   logic pace_mode    = 1'b0;
   logic hold_request = 1'b0;
   int   hold_left;
   int   gap_left, burst_left, stall_left;
   logic drv_free;
   vertex_item_type next_vertex;
   int   idle_cycles;

   function automatic longint to_coord(input logic [FIELD_BITS-1:0] raw);
      coord_type c;
      c = raw[COORD_BITS-1:0];
      return longint'(c);
   endfunction

   function automatic void test_edge(input longint ax, input longint ay,
                                     input longint bx, input longint by);
      longint qx, qy, x1, y1, x2, y2, dx, xi;
      logic [63:0]  mag, span, dy;
      logic [127:0] prod, quo;
      logic l1, l2;
      if (on_boundary)
         return;
      qx = to_coord(query_x_cfg);
      qy = to_coord(query_y_cfg);
      // lower endpoint first: by y, then by x
      if (ay > by || (ay == by && ax > bx)) begin
         x1 = bx; y1 = by; x2 = ax; y2 = ay;
      end else begin
         x1 = ax; y1 = ay; x2 = bx; y2 = by;
      end
      if ((x1 == x2 && qx == x1 && qy >= y1 && qy <= y2) ||
          (y1 == y2 && qy == y1 && qx >= x1 && qx <= x2) ||
          (qx == x1 && qy == y1)) begin
         on_boundary = 1'b1;
         return;
      end
      if (y1 <= qy && y2 > qy) begin
         l1 = x1 < qx;
         l2 = x2 < qx;
         if (l1 && l2) begin
            crossing_odd = ~crossing_odd;
         end else if (l1 || l2) begin
            dx   = x2 - x1;
            dy   = 64'(y2 - y1);
            span = 64'(qy - y1);
            mag  = (dx < 0) ? 64'(-dx) : 64'(dx);
            prod = {64'd0, mag} * {64'd0, span};
            quo  = prod / {64'd0, dy};
            xi   = (dx < 0) ? x1 - longint'(quo[63:0]) : x1 + longint'(quo[63:0]);
            if (xi == qx)
               on_boundary = 1'b1;
            else if (xi < qx)
               crossing_odd = ~crossing_odd;
         end
      end
   endfunction

   function automatic void classify_vertex(input logic [FIELD_BITS-1:0] x,
                                           input logic [FIELD_BITS-1:0] y,
                                           input logic last);
      longint vx, vy;
      vx = to_coord(x);
      vy = to_coord(y);
      if (corners_seen == 0) begin
         first_x = vx; first_y = vy;
         prev_x  = vx; prev_y  = vy;
         corners_seen = 1;
         if (last) begin
            class_expected_q.push_back(CLASS_OUTSIDE);
            corners_seen = 0;
            crossing_odd = 1'b0;
            on_boundary  = 1'b0;
         end
         return;
      end
      test_edge(prev_x, prev_y, vx, vy);
      prev_x = vx;
      prev_y = vy;
      corners_seen = 2;
      if (!last)
         return;
      test_edge(vx, vy, first_x, first_y);
      if (on_boundary)
         class_expected_q.push_back(CLASS_BOUNDARY);
      else if (crossing_odd)
         class_expected_q.push_back(CLASS_INSIDE);
      else
         class_expected_q.push_back(CLASS_OUTSIDE);
      corners_seen = 0;
      crossing_odd = 1'b0;
      on_boundary  = 1'b0;
   endfunction

   // vertex driver: in pace mode, bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left     <= 0;
         burst_left   <= 0;
      end else begin
         drv_free = !req_ch.valid || req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            classify_vertex(req_ch.vertex_x, req_ch.vertex_y, req_ch.final_vertex);
            vertices_accepted++;
         end
         if (drv_free) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (vertex_pending_q.size() != 0) begin
               next_vertex = vertex_pending_q.pop_front();
               req_ch.vertex_x     <= next_vertex.x;
               req_ch.vertex_y     <= next_vertex.y;
               req_ch.final_vertex <= next_vertex.last;
               req_ch.valid        <= 1'b1;
               if (burst_left > 1) begin
                  burst_left <= burst_left - 1;
               end else if (pace_mode) begin
                  burst_left <= $urandom_range(1, 30);
                  gap_left   <= $urandom_range(1, 25);
               end else begin
                  burst_left <= 0;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_request)
         hold_left <= LONG_HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // result monitor and ready pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (class_expected_q.size() == 0) begin
               $error("classification: no transaction expected, actual %0d",
                      rsp_ch.classification);
               mismatch_count++;
            end else if (rsp_ch.classification !== class_expected_q[0]) begin
               $error("classification: expected %0d, actual %0d",
                      class_expected_q[0], rsp_ch.classification);
               mismatch_count++;
               void'(class_expected_q.pop_front());
            end else begin
               void'(class_expected_q.pop_front());
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (pace_mode && $urandom_range(0, 4) == 0)
               stall_left <= $urandom_range(1, 18);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_vertex(input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
                               input logic last);
      vertex_item_type v;
      v.x = x;
      v.y = y;
      v.last = last;
      vertex_pending_q.push_back(v);
      vertices_queued++;
   endtask

   function automatic logic [FIELD_BITS-1:0] pick_coord(input logic [FIELD_BITS-1:0] center,
                                                        input int spread);
      int offset;
      offset = int'($urandom_range(0, 2 * spread)) - spread;
      case ($urandom_range(0, 15))
         0:       return $urandom;
         1:       return center;
         2:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return center + offset;
      endcase
   endfunction

   // random polygons clustered around the query point
   task automatic queue_polygons(input int budget);
      int placed, n, spread, k;
      placed = 0;
      while (placed < budget) begin
         case ($urandom_range(0, 9))
            0:       n = 1;
            1:       n = 2;
            2:       n = $urandom_range(7, 14);
            default: n = $urandom_range(3, 6);
         endcase
         case ($urandom_range(0, 2))
            0:       spread = 3;
            1:       spread = 60;
            default: spread = 200000;
         endcase
         for (k = 0; k < n; k++)
            queue_vertex(pick_coord(query_x_cfg, spread), pick_coord(query_y_cfg, spread),
                         k == n - 1);
         placed += n;
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (idx == REG_QUERY_X)
         query_x_cfg = value;
      else if (idx == REG_QUERY_Y)
         query_y_cfg = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // wait for every transaction to drain, then let the block settle
   task automatic wait_quiet();
      while (vertices_accepted != vertices_queued || class_expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int ph;
      logic [CSR_DATA_BITS-1:0] qx, qy;
      reset = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.vertex_x     = '0;
      req_ch.vertex_y     = '0;
      req_ch.final_vertex = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed polygons, query point at its reset value (origin)
      queue_vertex(5, 5, 1'b1);                      // lone vertex
      queue_vertex(-10, -10, 1'b0);                  // square around the point
      queue_vertex(10, -10, 1'b0);
      queue_vertex(10, 10, 1'b0);
      queue_vertex(-10, 10, 1'b1);
      queue_vertex(-5, -5, 1'b0);                    // two vertices, crossing lands on qx
      queue_vertex(5, 5, 1'b1);
      queue_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
      queue_vertex(32'h7fff_ffff, 32'h8000_0000, 1'b0);
      queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      queue_vertex(32'h8000_0000, 32'h7fff_ffff, 1'b1);
      queue_vertex(32'h8000_0000, 32'h8000_0000, 1'b0); // full-range diagonal
      queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      queue_vertex(32'h8000_0000, 32'h7fff_ffff, 1'b1);
      queue_vertex(0, -3, 1'b0);                     // vertical edge through the point
      queue_vertex(0, 3, 1'b0);
      queue_vertex(4, 0, 1'b1);
      queue_vertex(-3, 0, 1'b0);                     // horizontal edge through the point
      queue_vertex(3, 0, 1'b0);
      queue_vertex(0, 5, 1'b1);
      queue_vertex(0, 0, 1'b0);                      // point is a vertex
      queue_vertex(5, 1, 1'b0);
      queue_vertex(1, 5, 1'b1);
      wait_quiet();

      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin qx = 32'h8000_0000; qy = 32'h7fff_ffff; end
            1: begin qx = 32'h7fff_ffff; qy = 32'h8000_0000; end
            2: begin qx = 7;             qy = -3;            end
            default: begin qx = $urandom; qy = $urandom; end
         endcase
         csr_write(REG_QUERY_X, qx);
         csr_write(REG_QUERY_Y, qy);
         pace_mode <= (ph != 3);
         queue_polygons(PHASE_ITEMS);
         if (ph == 2) begin
            // stall results long enough that the block backs up its input
            @(posedge clock);
            hold_request <= 1'b1;
            @(posedge clock);
            hold_request <= 1'b0;
         end
         wait_quiet();
      end

      if (mismatch_count == 0 && class_expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- point_in_polygon_classify.f -----
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_if.sv
rtl/pip_divider.sv
rtl/pip_csr.sv
rtl/pip_edge.sv
rtl/point_in_polygon_classify.sv
dv/point_in_polygon_classify_tb.sv
